// ===== rtl/flux_split_stencil_update_core_defines.svh =====
// Assertion macros used by the flux-split stencil core.
`ifndef FLUX_SPLIT_STENCIL_UPDATE_CORE_DEFINES_SVH
`define FLUX_SPLIT_STENCIL_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fsu_pkg.sv =====
// Package with widths, latencies, status codes and pipeline types of the stencil core.
`default_nettype none
package fsu_pkg;

  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int TSTEP_W  = 31;
  localparam logic [TSTEP_W-1:0] TSTEP_RST = 31'd655;

  // Coefficient divider: numerator 3*(t+x)+4*y, divisor 3*J.
  localparam int NUM_W    = 36;
  localparam int DEN_W    = 34;
  localparam int DMAG_W   = 33;
  localparam int QUO_W    = 33;
  localparam int REM_W    = NUM_W + FRAC_W;

  // dt*J after the fraction shift.
  localparam int DTJ_W    = 47;

  localparam int DIV_LAT  = QUO_W + 3;
  localparam int FLUX_LAT = 4;
  localparam int UPD_LAT  = 3;
  localparam int TOTAL_LAT = DIV_LAT + FLUX_LAT + UPD_LAT + 1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_JZERO = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Side data that waits beside the coefficient dividers.
  typedef struct packed {
    logic signed [WORD_W-1:0] uc;
    logic signed [WORD_W-1:0] ul;
    logic signed [WORD_W-1:0] ur;
    logic signed [WORD_W-1:0] ud;
    logic signed [WORD_W-1:0] uu;
    logic signed [DTJ_W-1:0]  dtj;
    logic                     jzero;
  } div_side_t;

  // Side data that waits beside the flux stage.
  typedef struct packed {
    logic signed [WORD_W-1:0] uc;
    logic signed [DTJ_W-1:0]  dtj;
    logic                     jzero;
    logic                     sat;
  } flux_side_t;

  // Side data that waits beside the update stage.
  typedef struct packed {
    logic                     jzero;
    logic                     sat;
    logic signed [WORD_W-1:0] rhs;
  } upd_side_t;

endpackage
`default_nettype wire

// ===== rtl/fsu_coef_div.sv =====
// Pipelined coefficient unit: (3*(t+x)+4*y)*2^F / (3*J), truncated and saturated.
`default_nettype none
module fsu_coef_div (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]     m_dt_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]     m_dx_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]     m_dy_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]     jac_i,
  output logic                                       valid_o,
  output logic signed [fsu_pkg::WORD_W-1:0]          coef_o,
  output logic                                       sat_o
);

  localparam int NW = fsu_pkg::NUM_W;
  localparam int DW = fsu_pkg::DEN_W;
  localparam int MW = fsu_pkg::DMAG_W;
  localparam int QB = fsu_pkg::QUO_W;
  localparam int RW = fsu_pkg::REM_W;
  localparam int FW = fsu_pkg::FRAC_W;
  localparam int WW = fsu_pkg::WORD_W;
  localparam int TW = RW + MW;

  // Stage A: numerator and divisor in signed form.
  logic                 va_q;
  logic signed [NW-1:0] num_q, num_d;
  logic signed [DW-1:0] den_q, den_d;
  logic signed [NW-1:0] t_e, x_e, y_e, tx;
  logic signed [DW-1:0] j_e;

  always_comb begin
    t_e   = {{(NW-WW){m_dt_i[WW-1]}}, m_dt_i};
    x_e   = {{(NW-WW){m_dx_i[WW-1]}}, m_dx_i};
    y_e   = {{(NW-WW){m_dy_i[WW-1]}}, m_dy_i};
    j_e   = {{(DW-WW){jac_i[WW-1]}}, jac_i};
    tx    = t_e + x_e;
    num_d = (tx <<< 1) + tx + (y_e <<< 2);
    den_d = (j_e <<< 1) + j_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
  end

  // Iteration registers; index 0 holds the magnitudes, index k the quotient bits from the MSB down to bit QB-k.
  logic          v_q   [0:QB];
  logic [RW-1:0] rem_q [0:QB];
  logic [MW-1:0] dm_q  [0:QB];
  logic [QB-1:0] quo_q [0:QB];
  logic          ng_q  [0:QB];
  logic          ov_q  [0:QB];

  logic [NW-1:0] nmag;
  logic [DW-1:0] dmag;

  always_comb begin
    nmag = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
    dmag = den_q[DW-1] ? DW'(-den_q) : DW'(den_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= {nmag, {FW{1'b0}}};
    dm_q[0]  <= dmag[MW-1:0];
    quo_q[0] <= '0;
    ng_q[0]  <= num_q[NW-1] ^ den_q[DW-1];
    ov_q[0]  <= 1'b0;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_iter
    localparam int BIT = QB - k;
    logic [TW-1:0] trial;
    logic [TW-1:0] rem_ext;
    logic          take;
    logic          ovf;

    always_comb begin
      trial   = {{RW{1'b0}}, dm_q[k-1]} << BIT;
      rem_ext = {{MW{1'b0}}, rem_q[k-1]};
      take    = rem_ext >= trial;
      // The quotient needs more than QB bits exactly when |num| >= |den| * 2^(QB-F).
      if (k == 1) begin
        ovf = {{FW{1'b0}}, rem_q[k-1][RW-1:FW]} >=
              RW'({dm_q[k-1], {(QB-FW){1'b0}}});
      end else begin
        ovf = ov_q[k-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? RW'(rem_ext - trial) : rem_q[k-1];
      quo_q[k] <= quo_q[k-1] | (QB'(take) << BIT);
      dm_q[k]  <= dm_q[k-1];
      ng_q[k]  <= ng_q[k-1];
      ov_q[k]  <= ovf;
    end
  end

  // Final stage: sign and saturation to the word range.
  logic [QB-1:0]        q;
  logic [QB-1:0]        q_neg;
  logic signed [WW-1:0] coef_d;
  logic                 sat_d;

  always_comb begin
    q      = quo_q[QB];
    q_neg  = QB'(-q);
    coef_d = WW'(q);
    sat_d  = 1'b0;
    if (ov_q[QB]) begin
      sat_d  = 1'b1;
      coef_d = ng_q[QB] ? fsu_pkg::WMIN : fsu_pkg::WMAX;
    end else if (!ng_q[QB]) begin
      if (|q[QB-1:WW-1]) begin
        sat_d  = 1'b1;
        coef_d = fsu_pkg::WMAX;
      end
    end else begin
      if ((|q[QB-1:WW]) || (q[WW-1] && (|q[WW-2:0]))) begin
        sat_d  = 1'b1;
        coef_d = fsu_pkg::WMIN;
      end else begin
        coef_d = q_neg[WW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    coef_o <= coef_d;
    sat_o  <= sat_d;
  end

endmodule
`default_nettype wire

// ===== rtl/fsu_flux.sv =====
// Flux-split stencil: six fluxes, upwind selection, sum, negation and saturation.
`default_nettype none
module fsu_flux (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]  coef_a_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]  coef_b_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]  val_c_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]  val_l_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]  val_r_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]  val_d_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]  val_u_i,
  output logic                                    valid_o,
  output logic signed [fsu_pkg::WORD_W-1:0]       rhs_o,
  output logic                                    sat_o
);

  localparam int WW = fsu_pkg::WORD_W;
  localparam int FW = fsu_pkg::FRAC_W;
  localparam int PW = 2 * WW;
  localparam int FLW = PW - FW;
  localparam int SW = FLW + 4;

  logic [2:0] v_q;

  // Stage 1: products.
  logic signed [PW-1:0] p_ac_q, p_al_q, p_ar_q, p_bc_q, p_bd_q, p_bu_q;

  always_ff @(posedge clk_i) begin
    p_ac_q <= coef_a_i * val_c_i;
    p_al_q <= coef_a_i * val_l_i;
    p_ar_q <= coef_a_i * val_r_i;
    p_bc_q <= coef_b_i * val_c_i;
    p_bd_q <= coef_b_i * val_d_i;
    p_bu_q <= coef_b_i * val_u_i;
  end

  // Stage 2: floor shift, upwind parts, pair sums.
  logic signed [FLW-1:0] f_ac, f_al, f_ar, f_bc, f_bd, f_bu;
  logic signed [SW-1:0]  e_ac, e_al, e_ar, e_bc, e_bd, e_bu;
  logic signed [SW-1:0]  s1_q, s2_q, s3_q;

  always_comb begin
    f_ac = FLW'(p_ac_q >>> FW);
    f_al = FLW'(p_al_q >>> FW);
    f_ar = FLW'(p_ar_q >>> FW);
    f_bc = FLW'(p_bc_q >>> FW);
    f_bd = FLW'(p_bd_q >>> FW);
    f_bu = FLW'(p_bu_q >>> FW);
    e_ac = SW'(f_ac);
    e_al = SW'(f_al);
    e_ar = SW'(f_ar);
    e_bc = SW'(f_bc);
    e_bd = SW'(f_bd);
    e_bu = SW'(f_bu);
  end

  // Fp(c) - Fm(c) is the magnitude of the centre flux.
  always_ff @(posedge clk_i) begin
    s1_q <= (e_ac[SW-1] ? -e_ac : e_ac) - (e_al[SW-1] ? '0 : e_al);
    s2_q <= (e_ar[SW-1] ? e_ar : '0) + (e_bc[SW-1] ? -e_bc : e_bc);
    s3_q <= (e_bu[SW-1] ? e_bu : '0) - (e_bd[SW-1] ? '0 : e_bd);
  end

  // Stage 3: total.
  logic signed [SW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    sum_q <= s1_q + s2_q + s3_q;
  end

  // Stage 4: negate and saturate.
  logic signed [SW-1:0] neg_sum;
  logic                 ovf;

  always_comb begin
    neg_sum = -sum_q;
    ovf     = (neg_sum[SW-1:WW-1] != {(SW-WW+1){1'b0}}) &&
              (neg_sum[SW-1:WW-1] != {(SW-WW+1){1'b1}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else begin
      v_q     <= {v_q[1:0], valid_i};
      valid_o <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    sat_o <= ovf;
    if (ovf) begin
      rhs_o <= neg_sum[SW-1] ? fsu_pkg::WMIN : fsu_pkg::WMAX;
    end else begin
      rhs_o <= neg_sum[WW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fsu_update.sv =====
// Explicit Euler update u + floor(dtJ*rhs / 2^F) with the product split in two halves.
`default_nettype none
module fsu_update (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]  rhs_i,
  input  wire logic signed [fsu_pkg::DTJ_W-1:0]   dtj_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]  uc_i,
  output logic                                    valid_o,
  output logic signed [fsu_pkg::WORD_W-1:0]       next_o,
  output logic                                    sat_o
);

  localparam int WW = fsu_pkg::WORD_W;
  localparam int FW = fsu_pkg::FRAC_W;
  localparam int DW = fsu_pkg::DTJ_W;
  localparam int HW = DW - FW;
  localparam int LW = FW + 1 + WW;
  localparam int HPW = HW + WW;
  localparam int SW = HPW + 1;

  logic [1:0] v_q;

  // Stage 1: low and high partial products of dtJ*rhs.
  logic signed [LW-1:0]  p_lo_q;
  logic signed [HPW-1:0] p_hi_q;
  logic signed [FW:0]    lo_part;
  logic signed [HW-1:0]  hi_part;
  logic signed [WW-1:0]  uc_q;

  always_comb begin
    lo_part = {1'b0, dtj_i[FW-1:0]};
    hi_part = dtj_i[DW-1:FW];
  end

  always_ff @(posedge clk_i) begin
    p_lo_q <= LW'(lo_part) * LW'(rhs_i);
    p_hi_q <= HPW'(hi_part) * HPW'(rhs_i);
    uc_q   <= uc_i;
  end

  // Stage 2: hi + floor(lo / 2^F) + u.
  logic signed [SW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    sum_q <= SW'(p_hi_q) + SW'(p_lo_q >>> FW) + SW'(uc_q);
  end

  // Stage 3: saturate.
  logic ovf;

  always_comb begin
    ovf = (sum_q[SW-1:WW-1] != {(SW-WW+1){1'b0}}) &&
          (sum_q[SW-1:WW-1] != {(SW-WW+1){1'b1}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else begin
      v_q     <= {v_q[0], valid_i};
      valid_o <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    sat_o <= ovf;
    if (ovf) begin
      next_o <= sum_q[SW-1] ? fsu_pkg::WMIN : fsu_pkg::WMAX;
    end else begin
      next_o <= sum_q[WW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/flux_split_stencil_update_core.sv =====
// Each word taken on start reaches done_o through the dividers, flux stage, update stage and output register.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Most of the pipeline lies in the two coefficient dividers, one quotient bit per stage.
// Reset clears all valid bits and loads time_step with 655; words in flight are dropped.
`default_nettype none
`include "flux_split_stencil_update_core_defines.svh"
module flux_split_stencil_update_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Command channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    value_center_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    value_left_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    value_right_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    value_down_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    value_up_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    jacobian_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    xi_dx_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    xi_dy_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    xi_dt_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    eta_dx_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    eta_dy_i,
  input  wire logic signed [fsu_pkg::WORD_W-1:0]    eta_dt_i,
  // Result strobe
  output logic                                      done_o,
  output logic signed [fsu_pkg::WORD_W-1:0]         right_hand_side_o,
  output logic signed [fsu_pkg::WORD_W-1:0]         next_value_o,
  output logic [1:0]                                status_o,
  // Time-step register write channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [fsu_pkg::TSTEP_W-1:0]          cfg_data_i
);

  localparam int WW  = fsu_pkg::WORD_W;
  localparam int FW  = fsu_pkg::FRAC_W;
  localparam int DTW = fsu_pkg::DTJ_W;
  localparam int PW  = 2 * WW;
  localparam int LAT = fsu_pkg::TOTAL_LAT;

  // The pipeline has no back-pressure, so a word is taken on every start.
  logic accept;
  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Time step register; the user must write it only while the pipeline is empty, the block does not enforce it.
  logic [fsu_pkg::TSTEP_W-1:0] tstep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstep_q <= fsu_pkg::TSTEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tstep_q <= cfg_data_i;
    end
  end

  // Both wave coefficients are formed in parallel by identical divider pipelines.
  logic                 va, vb;
  logic signed [WW-1:0] coef_a, coef_b;
  logic                 sat_a, sat_b;

  fsu_coef_div u_div_xi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .m_dt_i  (xi_dt_i),
    .m_dx_i  (xi_dx_i),
    .m_dy_i  (xi_dy_i),
    .jac_i   (jacobian_i),
    .valid_o (va),
    .coef_o  (coef_a),
    .sat_o   (sat_a)
  );

  fsu_coef_div u_div_eta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .m_dt_i  (eta_dt_i),
    .m_dx_i  (eta_dx_i),
    .m_dy_i  (eta_dy_i),
    .jac_i   (jacobian_i),
    .valid_o (vb),
    .coef_o  (coef_b),
    .sat_o   (sat_b)
  );

  // dt*J is formed on entry and then waits with the neighbour values
  // for as long as the dividers take.
  fsu_pkg::div_side_t side1_q [0:fsu_pkg::DIV_LAT-1];
  fsu_pkg::div_side_t side1_d;
  logic signed [PW-1:0] dtj_full;

  always_comb begin
    dtj_full      = $signed({1'b0, tstep_q}) * jacobian_i;
    side1_d.uc    = value_center_i;
    side1_d.ul    = value_left_i;
    side1_d.ur    = value_right_i;
    side1_d.ud    = value_down_i;
    side1_d.uu    = value_up_i;
    side1_d.dtj   = dtj_full[FW+DTW-1:FW];
    side1_d.jzero = jacobian_i == '0;
  end

  always_ff @(posedge clk_i) begin
    side1_q[0] <= side1_d;
    for (int k = 1; k < fsu_pkg::DIV_LAT; k++) begin
      side1_q[k] <= side1_q[k-1];
    end
  end

  fsu_pkg::div_side_t s1;
  assign s1 = side1_q[fsu_pkg::DIV_LAT-1];

  // Flux stage: upwind split and the negated sum.
  logic                 vf;
  logic signed [WW-1:0] rhs;
  logic                 sat_r;

  fsu_flux u_flux (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (va),
    .coef_a_i (coef_a),
    .coef_b_i (coef_b),
    .val_c_i  (s1.uc),
    .val_l_i  (s1.ul),
    .val_r_i  (s1.ur),
    .val_d_i  (s1.ud),
    .val_u_i  (s1.uu),
    .valid_o  (vf),
    .rhs_o    (rhs),
    .sat_o    (sat_r)
  );

  fsu_pkg::flux_side_t side2_q [0:fsu_pkg::FLUX_LAT-1];
  fsu_pkg::flux_side_t side2_d;

  always_comb begin
    side2_d.uc    = s1.uc;
    side2_d.dtj   = s1.dtj;
    side2_d.jzero = s1.jzero;
    side2_d.sat   = sat_a || sat_b;
  end

  always_ff @(posedge clk_i) begin
    side2_q[0] <= side2_d;
    for (int k = 1; k < fsu_pkg::FLUX_LAT; k++) begin
      side2_q[k] <= side2_q[k-1];
    end
  end

  fsu_pkg::flux_side_t s2;
  assign s2 = side2_q[fsu_pkg::FLUX_LAT-1];

  // Euler update.
  logic                 vu;
  logic signed [WW-1:0] next_val;
  logic                 sat_n;

  fsu_update u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vf),
    .rhs_i   (rhs),
    .dtj_i   (s2.dtj),
    .uc_i    (s2.uc),
    .valid_o (vu),
    .next_o  (next_val),
    .sat_o   (sat_n)
  );

  fsu_pkg::upd_side_t side3_q [0:fsu_pkg::UPD_LAT-1];
  fsu_pkg::upd_side_t side3_d;

  always_comb begin
    side3_d.jzero = s2.jzero;
    side3_d.sat   = s2.sat || sat_r;
    side3_d.rhs   = rhs;
  end

  always_ff @(posedge clk_i) begin
    side3_q[0] <= side3_d;
    for (int k = 1; k < fsu_pkg::UPD_LAT; k++) begin
      side3_q[k] <= side3_q[k-1];
    end
  end

  fsu_pkg::upd_side_t s3;
  assign s3 = side3_q[fsu_pkg::UPD_LAT-1];

  // Output register. A zero Jacobian forces both results to zero, whatever the
  // dividers made of it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vu;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3.jzero) begin
      right_hand_side_o <= '0;
      next_value_o      <= '0;
      status_o          <= fsu_pkg::ST_JZERO;
    end else begin
      right_hand_side_o <= s3.rhs;
      next_value_o      <= next_val;
      status_o          <= (s3.sat || sat_n) ? fsu_pkg::ST_SAT : fsu_pkg::ST_OK;
    end
  end

  // Every accepted word comes out after the fixed latency, and nothing else does.
  `FSU_ASSERT_NOW(a_lat_fwd, accept, ##LAT done_o, "accepted word did not complete on time")
  `FSU_ASSERT_NOW(a_lat_bwd, done_o, $past(accept, LAT), "result without a matching word")
  `FSU_ASSERT_NOW(a_jzero, done_o && status_o == fsu_pkg::ST_JZERO, right_hand_side_o == '0 && next_value_o == '0, "zero Jacobian result not zero")
  `FSU_ASSERT_NOW(a_div_sync, va || vb, va == vb, "coefficient dividers out of step")

endmodule
`default_nettype wire

// ===== tb/flux_split_stencil_update_core_tb.sv =====
// Self-checking testbench of the flux-split stencil core, with directed and random grid points.
`default_nettype none
module flux_split_stencil_update_core_tb;

  typedef logic signed [fsu_pkg::WORD_W-1:0] word_t;

  // One grid point as it is offered on the command channel.
  typedef struct {
    word_t uc, ul, ur, ud, uu, jac;
    word_t xdx, xdy, xdt, edx, edy, edt;
  } grid_point_t;

  // One updated point as the core reports it.
  typedef struct {
    word_t      rhs;
    word_t      nxt;
    logic [1:0] status;
  } point_update_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  grid_point_t                   pt_drv;
  logic                          done_o;
  word_t                         right_hand_side_o;
  word_t                         next_value_o;
  logic [1:0]                    status_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [fsu_pkg::TSTEP_W-1:0]   cfg_data_i;

  // The predictor's own copy of the Euler time step.
  logic [fsu_pkg::TSTEP_W-1:0]   dt_model;
  point_update_t                 pending_updates[$];
  int                            fail_count;
  bit                            idle_enabled;

  flux_split_stencil_update_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .value_center_i    (pt_drv.uc),
    .value_left_i      (pt_drv.ul),
    .value_right_i     (pt_drv.ur),
    .value_down_i      (pt_drv.ud),
    .value_up_i        (pt_drv.uu),
    .jacobian_i        (pt_drv.jac),
    .xi_dx_i           (pt_drv.xdx),
    .xi_dy_i           (pt_drv.xdy),
    .xi_dt_i           (pt_drv.xdt),
    .eta_dx_i          (pt_drv.edx),
    .eta_dy_i          (pt_drv.edy),
    .eta_dt_i          (pt_drv.edt),
    .done_o            (done_o),
    .right_hand_side_o (right_hand_side_o),
    .next_value_o      (next_value_o),
    .status_o          (status_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All intermediate values are held in 64 bits, which is wide
  // enough for every product the update forms once the huge-increment case
  // has been caught.
  // ---------------------------------------------------------------------------

  // Clamps a wide value to the word range and notes when it had to.
  function automatic longint clamp_word(longint v, inout bit clipped);
    if (v > longint'(fsu_pkg::WMAX)) begin
      clipped = 1'b1;
      return longint'(fsu_pkg::WMAX);
    end
    if (v < longint'(fsu_pkg::WMIN)) begin
      clipped = 1'b1;
      return longint'(fsu_pkg::WMIN);
    end
    return v;
  endfunction

  // Drops the fraction bits, rounding toward minus infinity.
  function automatic longint drop_frac(longint v);
    return v >>> fsu_pkg::FRAC_W;
  endfunction

  // Wave speed (t + x + 4/3*y) / J; the division truncates toward zero.
  function automatic longint wave_speed(word_t t, word_t x, word_t y, word_t j,
                                        inout bit clipped);
    longint num;
    num = 3 * (longint'(t) + longint'(x)) + 4 * longint'(y);
    return clamp_word((num * (64'sd1 <<< fsu_pkg::FRAC_W)) / (3 * longint'(j)), clipped);
  endfunction

  function automatic longint up_part(longint f);
    return (f > 0) ? f : 0;
  endfunction

  function automatic longint down_part(longint f);
    return (f < 0) ? f : 0;
  endfunction

  function automatic point_update_t predict_update(grid_point_t p);
    point_update_t     r;
    bit                clipped;
    longint            a, b, sum, rhs, dtj, nxt;
    longint unsigned   ma, mb;
    clipped = 1'b0;
    if (p.jac == 0) begin
      r.rhs    = '0;
      r.nxt    = '0;
      r.status = fsu_pkg::ST_JZERO;
      return r;
    end
    a = wave_speed(p.xdt, p.xdx, p.xdy, p.jac, clipped);
    b = wave_speed(p.edt, p.edx, p.edy, p.jac, clipped);
    sum = up_part(drop_frac(a * p.uc)) - up_part(drop_frac(a * p.ul))
        + down_part(drop_frac(a * p.ur)) - down_part(drop_frac(a * p.uc))
        + up_part(drop_frac(b * p.uc)) - up_part(drop_frac(b * p.ud))
        + down_part(drop_frac(b * p.uu)) - down_part(drop_frac(b * p.uc));
    rhs = clamp_word(-sum, clipped);
    dtj = drop_frac(longint'({33'd0, dt_model}) * longint'(p.jac));
    ma  = (dtj < 0) ? longint'(-dtj) : dtj;
    mb  = (rhs < 0) ? longint'(-rhs) : rhs;
    // A product beyond 2^62 cannot land in the word, so it pins to a rail.
    if (mb != 0 && ma > (64'h4000_0000_0000_0000 / mb)) begin
      clipped = 1'b1;
      nxt = ((dtj < 0) != (rhs < 0)) ? longint'(fsu_pkg::WMIN) : longint'(fsu_pkg::WMAX);
    end else begin
      nxt = clamp_word(longint'(p.uc) + drop_frac(dtj * rhs), clipped);
    end
    r.rhs    = rhs[fsu_pkg::WORD_W-1:0];
    r.nxt    = nxt[fsu_pkg::WORD_W-1:0];
    r.status = clipped ? fsu_pkg::ST_SAT : fsu_pkg::ST_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker. The core cannot be held off, so every cycle with done_o
  // high carries one updated point that must match the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    point_update_t want;
    if (rst_ni && done_o) begin
      if (pending_updates.size() == 0) begin
        $error("result with no prediction waiting: rhs %0d next %0d status %0d",
               right_hand_side_o, next_value_o, status_o);
        fail_count++;
      end else begin
        want = pending_updates.pop_front();
        if (right_hand_side_o !== want.rhs) begin
          $error("right_hand_side: expected %0d, got %0d", want.rhs, right_hand_side_o);
          fail_count++;
        end
        if (next_value_o !== want.nxt) begin
          $error("next_value: expected %0d, got %0d", want.nxt, next_value_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one point and holds it until the core takes it. Start stays high
  // into the next word unless an idle cycle is drawn.
  task automatic send_point(grid_point_t p);
    if (idle_enabled && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    pt_drv <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_updates = {pending_updates, predict_update(p)};
  endtask

  // Takes start low once a run of words is over.
  task automatic stop_sending();
    start <= 1'b0;
  endtask

  // Waits until every predicted point has come back, then lets the pipeline
  // drain fully before anything touches the register.
  task automatic wait_drained();
    stop_sending();
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (fsu_pkg::TOTAL_LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_time_step(logic [fsu_pkg::TSTEP_W-1:0] dt);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= dt;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    dt_model    = dt;
    cfg_valid_i <= 1'b0;
  endtask

  // Draws a word: full range, a small magnitude, zero, or one of the rails.
  function automatic word_t draw_word();
    case ($urandom_range(0, 9))
      0:       return fsu_pkg::WMAX;
      1:       return fsu_pkg::WMIN;
      2:       return '0;
      3, 4, 5: return word_t'($urandom);
      default: return word_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  // Well-formed points have modest metrics and a Jacobian of 1/4 to 4 in either
  // sign, so their wave speeds stay small; the rest is raw noise.
  function automatic grid_point_t draw_point();
    grid_point_t p;
    bit          tame;
    tame  = ($urandom_range(0, 99) < 70);
    p.uc  = draw_word();
    p.ul  = draw_word();
    p.ur  = draw_word();
    p.ud  = draw_word();
    p.uu  = draw_word();
    if (tame) begin
      p.jac = word_t'($urandom_range(1 << 14, 1 << 18));
      if ($urandom_range(0, 1)) p.jac = -p.jac;
      p.xdx = word_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      p.xdy = word_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      p.xdt = word_t'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
      p.edx = word_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      p.edy = word_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      p.edt = word_t'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    end else begin
      p.jac = ($urandom_range(0, 19) == 0) ? word_t'(0) : draw_word();
      p.xdx = draw_word();
      p.xdy = draw_word();
      p.xdt = draw_word();
      p.edx = draw_word();
      p.edy = draw_word();
      p.edt = draw_word();
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Rails of every field, a zero Jacobian, saturating wave speeds and rhs,
  // and the huge increment that pins next_value to a rail.
  task automatic test_directed();
    grid_point_t p;
    p = '{default: '0};
    p.jac = 32'sh0001_0000;
    send_point(p);
    p.jac = '0;
    p.uc  = 32'sh0003_0000;
    send_point(p);
    p = '{default: fsu_pkg::WMAX};
    send_point(p);
    p = '{default: fsu_pkg::WMIN};
    send_point(p);
    p.jac = fsu_pkg::WMAX;
    send_point(p);
    p = '{default: fsu_pkg::WMAX};
    p.jac = 32'sd1;
    send_point(p);
    p.jac = -32'sd1;
    p.ul  = fsu_pkg::WMIN;
    p.ud  = fsu_pkg::WMIN;
    send_point(p);
    // Moderate point with a Jacobian of one: an ordinary update.
    p = '{default: '0};
    p.jac = 32'sh0001_0000;
    p.uc  = 32'sh0002_0000;
    p.ul  = 32'sh0001_0000;
    p.ur  = -32'sh0001_8000;
    p.ud  = 32'sh0000_8000;
    p.uu  = -32'sh0003_0000;
    p.xdx = 32'sh0000_C000;
    p.xdy = -32'sh0000_4000;
    p.xdt = 32'sh0000_1000;
    p.edx = -32'sh0001_0000;
    p.edy = 32'sh0000_3000;
    p.edt = -32'sh0000_0800;
    send_point(p);
    p.jac = -32'sh0001_0000;
    send_point(p);
    // A large metric with a large Jacobian gives a huge increment.
    p.jac = 32'sh4000_0000;
    p.xdx = 32'sh7000_0000;
    p.uc  = fsu_pkg::WMIN;
    p.ul  = fsu_pkg::WMAX;
    send_point(p);
    p.jac = fsu_pkg::WMIN;
    send_point(p);
  endtask

  task automatic test_random_points(int count);
    repeat (count) send_point(draw_point());
  endtask

  // The sender stops and waits for every outstanding update before resuming.
  task automatic test_pause_until_empty();
    test_random_points(30);
    stop_sending();
    while (pending_updates.size() != 0) @(posedge clk_i);
    test_random_points(30);
  endtask

  // Back-to-back words with no idle cycle at all.
  task automatic test_full_rate();
    idle_enabled = 1'b0;
    test_random_points(250);
    idle_enabled = 1'b1;
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    pt_drv       = '{default: '0};
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    dt_model     = fsu_pkg::TSTEP_RST;
    fail_count   = 0;
    idle_enabled = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset value of the time step is checked before any write.
    test_directed();
    test_random_points(200);
    write_time_step('0);
    test_directed();
    test_random_points(150);
    write_time_step({fsu_pkg::TSTEP_W{1'b1}});
    test_directed();
    test_random_points(150);
    write_time_step(31'h0001_0000);
    test_full_rate();
    test_pause_until_empty();
    write_time_step(31'($urandom));
    test_random_points(200);
    write_time_step(31'($urandom_range(0, 1 << 17)));
    test_random_points(200);

    wait_drained();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
